FILE: design/bpe_pkg.sv
package bpe_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int SEGMENTS_DEF      = 8;
  localparam int LEVEL_BITS_DEF    = 16;
  localparam int DURATION_BITS_DEF = 16;

  // The sample clock and segment start time wrap at 20 bits.
  localparam int TIME_BITS      = 20;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Command codes carried by an input word. The fourth code does nothing.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_LOAD    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEGMENT_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_ENABLE     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_RESTART    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SUSTAIN_SEGMENT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_LEVEL   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_MODE       = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         seg_index;
    logic [15:0]        seg_duration;
    logic signed [15:0] seg_level;
  } item_t;

  typedef struct packed {
    logic signed [15:0] level_out;
    logic               finished;
    logic [3:0]         segment_now;
  } result_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_SEG,
    OP_RESTART,
    OP_ELAPSED,
    OP_LATCH_SEG,
    OP_ADVANCE,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RAMP_SET,
    OP_STEP_SET,
    OP_SET_ENDED,
    OP_FINISH
  } op_t;

  // Jump conditions, one per control word.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IS_TICK,
    C_IS_RESTART,
    C_IS_LOAD,
    C_POS_LT_COUNT,
    C_NO_LOOP,
    C_COUNT_ZERO,
    C_ELAPSED_LT_DT,
    C_IS_SUSTAIN,
    C_STEP_MODE,
    C_DIV_MORE,
    C_OUT_BLOCKED
  } cond_t;

  typedef logic [4:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Flags the datapath reports for the jump conditions.
  typedef struct packed {
    logic is_tick;
    logic is_restart;
    logic is_load;
    logic pos_lt_count;
    logic no_loop;
    logic count_zero;
    logic elapsed_lt_dt;
    logic is_sustain;
    logic step_mode;
    logic div_more;
    logic out_blocked;
  } status_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } ctrl_t;

  // Program addresses.
  localparam step_t ST_DISPATCH    = 5'd0;
  localparam step_t ST_CHK_RESTART = 5'd1;
  localparam step_t ST_CHK_LOAD    = 5'd2;
  localparam step_t ST_NOOP        = 5'd3;
  localparam step_t ST_LOAD        = 5'd4;
  localparam step_t ST_RESTART     = 5'd5;
  localparam step_t ST_TICK        = 5'd6;
  localparam step_t ST_CHK_LOOP    = 5'd7;
  localparam step_t ST_WRAP        = 5'd8;
  localparam step_t ST_FETCH       = 5'd9;
  localparam step_t ST_LATCH       = 5'd10;
  localparam step_t ST_TEST        = 5'd11;
  localparam step_t ST_SUSTAIN     = 5'd12;
  localparam step_t ST_ADVANCE     = 5'd13;
  localparam step_t ST_RAMP        = 5'd14;
  localparam step_t ST_DIV_INIT    = 5'd15;
  localparam step_t ST_DIV         = 5'd16;
  localparam step_t ST_RAMP_SET    = 5'd17;
  localparam step_t ST_STEP_SET    = 5'd18;
  localparam step_t ST_ENDED       = 5'd19;
  localparam step_t ST_DONE        = 5'd20;

  // Control store. Each word runs its operation, then jumps to the target
  // when the condition holds and falls through to the next word otherwise.
  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    unique case (s)
      ST_DISPATCH:    w = '{OP_NONE,      C_IS_TICK,       ST_TICK};
      ST_CHK_RESTART: w = '{OP_NONE,      C_IS_RESTART,    ST_RESTART};
      ST_CHK_LOAD:    w = '{OP_NONE,      C_IS_LOAD,       ST_LOAD};
      ST_NOOP:        w = '{OP_NONE,      C_ALWAYS,        ST_DONE};
      ST_LOAD:        w = '{OP_LOAD_SEG,  C_ALWAYS,        ST_DONE};
      ST_RESTART:     w = '{OP_RESTART,   C_ALWAYS,        ST_DONE};
      ST_TICK:        w = '{OP_NONE,      C_POS_LT_COUNT,  ST_FETCH};
      ST_CHK_LOOP:    w = '{OP_NONE,      C_NO_LOOP,       ST_ENDED};
      ST_WRAP:        w = '{OP_RESTART,   C_COUNT_ZERO,    ST_DONE};
      ST_FETCH:       w = '{OP_ELAPSED,   C_NEVER,         ST_DONE};
      ST_LATCH:       w = '{OP_LATCH_SEG, C_NEVER,         ST_DONE};
      ST_TEST:        w = '{OP_NONE,      C_ELAPSED_LT_DT, ST_RAMP};
      ST_SUSTAIN:     w = '{OP_NONE,      C_IS_SUSTAIN,    ST_DONE};
      ST_ADVANCE:     w = '{OP_ADVANCE,   C_ALWAYS,        ST_DONE};
      ST_RAMP:        w = '{OP_MUL,       C_STEP_MODE,     ST_STEP_SET};
      ST_DIV_INIT:    w = '{OP_DIV_INIT,  C_NEVER,         ST_DONE};
      ST_DIV:         w = '{OP_DIV_STEP,  C_DIV_MORE,      ST_DIV};
      ST_RAMP_SET:    w = '{OP_RAMP_SET,  C_ALWAYS,        ST_DONE};
      ST_STEP_SET:    w = '{OP_STEP_SET,  C_ALWAYS,        ST_DONE};
      ST_ENDED:       w = '{OP_SET_ENDED, C_ALWAYS,        ST_DONE};
      ST_DONE:        w = '{OP_FINISH,    C_OUT_BLOCKED,   ST_DONE};
      default:        w = '{OP_NONE,      C_ALWAYS,        ST_DONE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/bpe_ram.sv
module bpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bpe_sequencer.sv
module bpe_sequencer
  import bpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t  step;
  step_t  step_next;
  logic   busy;
  logic   busy_next;
  logic   jump;
  ucode_t uw;

  assign uw = ucode(step);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:         jump = 1'b0;
      C_ALWAYS:        jump = 1'b1;
      C_IS_TICK:       jump = status.is_tick;
      C_IS_RESTART:    jump = status.is_restart;
      C_IS_LOAD:       jump = status.is_load;
      C_POS_LT_COUNT:  jump = status.pos_lt_count;
      C_NO_LOOP:       jump = status.no_loop;
      C_COUNT_ZERO:    jump = status.count_zero;
      C_ELAPSED_LT_DT: jump = status.elapsed_lt_dt;
      C_IS_SUSTAIN:    jump = status.is_sustain;
      C_STEP_MODE:     jump = status.step_mode;
      C_DIV_MORE:      jump = status.div_more;
      C_OUT_BLOCKED:   jump = status.out_blocked;
      default:         jump = 1'b0;
    endcase
  end

  // Next step and busy flag.
  always_comb begin
    step_next = step;
    busy_next = busy;
    if (!busy) begin
      if (item_valid) begin
        step_next = ST_DISPATCH;
        busy_next = 1'b1;
      end
    end else begin
      step_next = jump ? uw.target : step_t'(step + 5'd1);
      if (uw.op == OP_FINISH && !status.out_blocked) begin
        busy_next = 1'b0;
      end
    end
  end

  // Outputs.
  always_comb begin
    item_ready  = !busy;
    ctrl.accept = item_valid && !busy;
    ctrl.op     = busy ? uw.op : OP_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_DISPATCH;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule

FILE: design/bpe_datapath.sv
module bpe_datapath
  import bpe_pkg::*;
#(
  parameter int SEGMENTS      = SEGMENTS_DEF,
  parameter int LEVEL_BITS    = LEVEL_BITS_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  item_t                     item,
  output logic                      result_valid,
  input  logic                      result_ready,
  output result_t                   result,
  input  ctrl_t                     ctrl,
  output status_t                   status
);

  localparam int POS_BITS  = $clog2(SEGMENTS + 1);
  localparam int ADDR_BITS = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int DIFF_BITS = LEVEL_BITS + 1;
  localparam int SUM_BITS  = LEVEL_BITS + 2;
  localparam int PROD_BITS = DIFF_BITS + TIME_BITS;
  localparam int CNT_BITS  = $clog2(DIFF_BITS + 1);
  localparam int CMP_BITS  = (DURATION_BITS > TIME_BITS) ? DURATION_BITS : TIME_BITS;
  localparam int RAM_WIDTH = DURATION_BITS + LEVEL_BITS;
  localparam longint LVL_MAX = (longint'(1) <<< (LEVEL_BITS - 1)) - 1;
  localparam longint LVL_MIN = -LVL_MAX - 1;
  localparam longint DUR_MAX = (longint'(1) <<< DURATION_BITS) - 1;
  localparam logic [7:0] SEG_LIMIT = 8'(SEGMENTS);

  function automatic logic signed [LEVEL_BITS-1:0] sat_level(input logic signed [15:0] v);
    longint w;
    w = longint'(v);
    if (w > LVL_MAX) begin
      w = LVL_MAX;
    end else if (w < LVL_MIN) begin
      w = LVL_MIN;
    end
    return LEVEL_BITS'(w);
  endfunction

  item_t                         item_r;
  logic [3:0]                    seg_count;
  logic                          loop_en;
  logic                          full_rst;
  logic signed [3:0]             sustain;
  logic signed [LEVEL_BITS-1:0]  init_level;
  logic                          step_mode;

  logic [TIME_BITS-1:0]          sample_time;
  logic [TIME_BITS-1:0]          seg_start;
  logic [POS_BITS-1:0]           seg_pos;
  logic signed [LEVEL_BITS-1:0]  cur_level;
  logic signed [LEVEL_BITS-1:0]  start_level;
  logic                          ended;

  logic [TIME_BITS-1:0]          elapsed_r;
  logic [DURATION_BITS-1:0]      dt_r;
  logic signed [LEVEL_BITS-1:0]  tgt_r;
  logic                          neg_r;
  logic [PROD_BITS-1:0]          prod_r;
  logic [DURATION_BITS-1:0]      rem_r;
  logic [DIFF_BITS-1:0]          quo_r;
  logic [CNT_BITS-1:0]           div_cnt;

  logic [7:0]                    count_eff;
  logic                          out_blocked;
  logic                          ram_we;
  logic [ADDR_BITS-1:0]          ram_waddr;
  logic [ADDR_BITS-1:0]          ram_raddr;
  logic [RAM_WIDTH-1:0]          ram_wdata;
  logic [RAM_WIDTH-1:0]          ram_rdata;
  logic [DURATION_BITS-1:0]      dur_sat;
  logic signed [DIFF_BITS-1:0]   diff;
  logic [DIFF_BITS-1:0]          mag;
  logic [DURATION_BITS:0]        trial;
  logic                          trial_ge;
  logic signed [SUM_BITS-1:0]    q_signed;
  logic signed [SUM_BITS-1:0]    ramp_sum;
  longint                        cur_wide;
  logic signed [15:0]            level_sat16;

  // Segment table: duration in the upper bits, target level in the lower.
  bpe_ram #(
    .WIDTH(RAM_WIDTH),
    .DEPTH(SEGMENTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    dur_sat   = (longint'(item_r.seg_duration) > DUR_MAX) ? DURATION_BITS'(DUR_MAX)
                                                          : DURATION_BITS'(item_r.seg_duration);
    ram_wdata = {dur_sat, sat_level($signed(item_r.seg_level))};
    ram_waddr = ADDR_BITS'(item_r.seg_index);
    ram_we    = (ctrl.op == OP_LOAD_SEG) && (8'(item_r.seg_index) < SEG_LIMIT);
    ram_raddr = ADDR_BITS'(seg_pos);
  end

  always_comb begin
    count_eff   = (8'(seg_count) > SEG_LIMIT) ? SEG_LIMIT : 8'(seg_count);
    out_blocked = result_valid && !result_ready;

    diff = DIFF_BITS'(tgt_r) - DIFF_BITS'(start_level);
    mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);

    trial    = {rem_r, quo_r[DIFF_BITS-1]};
    trial_ge = trial >= {1'b0, dt_r};

    q_signed = $signed(SUM_BITS'(quo_r));
    ramp_sum = SUM_BITS'(start_level) + (neg_r ? -q_signed : q_signed);

    cur_wide = longint'(cur_level);
    if (cur_wide > 64'sd32767) begin
      level_sat16 = 16'sh7fff;
    end else if (cur_wide < -64'sd32768) begin
      level_sat16 = 16'sh8000;
    end else begin
      level_sat16 = 16'(cur_wide);
    end
  end

  always_comb begin
    status.is_tick       = item_r.cmd == CMD_TICK;
    status.is_restart    = item_r.cmd == CMD_RESTART;
    status.is_load       = item_r.cmd == CMD_LOAD;
    status.pos_lt_count  = 8'(seg_pos) < count_eff;
    status.no_loop       = !loop_en;
    status.count_zero    = count_eff == 8'd0;
    status.elapsed_lt_dt = CMP_BITS'(elapsed_r) < CMP_BITS'(dt_r);
    status.is_sustain    = !sustain[3] && (8'(sustain[2:0]) == 8'(seg_pos));
    status.step_mode     = step_mode;
    status.div_more      = div_cnt > CNT_BITS'(1);
    status.out_blocked   = out_blocked;
  end

  // Configuration and envelope state.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count    <= '0;
      loop_en      <= 1'b0;
      full_rst     <= 1'b0;
      sustain      <= -4'sd1;
      init_level   <= '0;
      step_mode    <= 1'b0;
      sample_time  <= '0;
      seg_start    <= '0;
      seg_pos      <= '0;
      cur_level    <= '0;
      start_level  <= '0;
      ended        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEGMENT_COUNT:   seg_count  <= cfg_data[3:0];
          REG_LOOP_ENABLE:     loop_en    <= cfg_data[0];
          REG_FULL_RESTART:    full_rst   <= cfg_data[0];
          REG_SUSTAIN_SEGMENT: sustain    <= $signed(cfg_data[3:0]);
          REG_INITIAL_LEVEL:   init_level <= sat_level($signed(cfg_data));
          REG_STEP_MODE:       step_mode  <= cfg_data[0];
          default: ;
        endcase
      end

      // A new word in the output register wins over the one leaving it.
      if (ctrl.op == OP_FINISH && !out_blocked) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (ctrl.op)
        OP_RESTART: begin
          ended       <= 1'b0;
          sample_time <= '0;
          seg_pos     <= '0;
          seg_start   <= '0;
          if (full_rst) begin
            cur_level   <= init_level;
            start_level <= init_level;
          end else begin
            start_level <= cur_level;
          end
        end
        OP_ADVANCE: begin
          seg_start   <= seg_start + TIME_BITS'(dt_r);
          start_level <= tgt_r;
          seg_pos     <= seg_pos + POS_BITS'(1);
        end
        OP_RAMP_SET: begin
          cur_level   <= LEVEL_BITS'(ramp_sum);
          sample_time <= sample_time + TIME_BITS'(1);
        end
        OP_STEP_SET: begin
          cur_level   <= tgt_r;
          sample_time <= sample_time + TIME_BITS'(1);
        end
        OP_SET_ENDED: begin
          ended <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Working registers: item, elapsed, segment, product, divider, result.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      item_r <= item;
    end
    unique case (ctrl.op)
      OP_ELAPSED: begin
        elapsed_r <= sample_time - seg_start;
      end
      OP_LATCH_SEG: begin
        dt_r  <= ram_rdata[RAM_WIDTH-1:LEVEL_BITS];
        tgt_r <= $signed(ram_rdata[LEVEL_BITS-1:0]);
      end
      OP_MUL: begin
        neg_r  <= diff[DIFF_BITS-1];
        prod_r <= PROD_BITS'(mag) * PROD_BITS'(elapsed_r);
      end
      OP_DIV_INIT: begin
        // The product is below dt times two to the quotient width, so the
        // upper part already fits under the divisor.
        rem_r   <= DURATION_BITS'(prod_r >> DIFF_BITS);
        quo_r   <= prod_r[DIFF_BITS-1:0];
        div_cnt <= CNT_BITS'(DIFF_BITS);
      end
      OP_DIV_STEP: begin
        rem_r   <= trial_ge ? DURATION_BITS'(trial - {1'b0, dt_r}) : DURATION_BITS'(trial);
        quo_r   <= {quo_r[DIFF_BITS-2:0], trial_ge};
        div_cnt <= div_cnt - CNT_BITS'(1);
      end
      OP_FINISH: begin
        if (!out_blocked) begin
          result.level_out   <= level_sat16;
          result.finished    <= ended;
          result.segment_now <= 4'(seg_pos);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: design/breakpoint_envelope_generator.sv
// Breakpoint envelope generator and step sequencer.
//
// Input words arrive on item_valid/item_ready and carry a command: tick
// advances the envelope by one sample, restart returns to the first segment,
// load writes one entry (duration and target level) of the segment table.
// Every input word yields exactly one result word on result_valid/
// result_ready with the level, the finished flag and the current segment.
// Settings are written through cfg_we/cfg_index/cfg_data while idle.
//
// A short microprogram steps through each command. A ramping tick runs
// through the restoring divider, which retires one quotient bit per cycle.
// A step-mode tick or a segment change skips the divider, and a tick that
// loops back to the first segment first restarts the envelope. The next word
// is taken on the cycle after the result is registered.
//
// If the receiver stalls, the result register holds its word; the block
// still accepts and works on the next input word, then waits in its last
// step until the output register frees up. Reset clears the envelope state
// and settings; the segment table holds nothing until loaded.
module breakpoint_envelope_generator
  import bpe_pkg::*;
#(
  parameter int SEGMENTS      = SEGMENTS_DEF,
  parameter int LEVEL_BITS    = LEVEL_BITS_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  item_t                     item,
  output logic                      result_valid,
  input  logic                      result_ready,
  output result_t                   result
);

  // Operation strobes from the sequencer and jump flags back from the datapath.
  ctrl_t   ctrl;
  status_t status;

  bpe_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  bpe_datapath #(
    .SEGMENTS     (SEGMENTS),
    .LEVEL_BITS   (LEVEL_BITS),
    .DURATION_BITS(DURATION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .ctrl        (ctrl),
    .status      (status)
  );

endmodule

FILE: design/bpe_checker.sv
module bpe_checker
  import bpe_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A stalled result word holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // Reset empties the output and frees the input.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("block not idle after reset");

  // The input closes right after every accept while the word is in work.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input taken again right after an accept");

  // A new result only comes out of a word that was in work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result raised without a word in work");

endmodule

bind breakpoint_envelope_generator bpe_checker u_bpe_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);

FILE: test/tb.sv
module tb
  import bpe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The fourth command code has no name in the package. It changes nothing
  // and only reports the current state.
  localparam logic [1:0] CMD_IDLE = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item_word = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result_word;

  breakpoint_envelope_generator uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item_word),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Settings as the envelope sees them. They mirror every register write.
  logic [3:0]         cfg_count;
  logic               cfg_loop;
  logic               cfg_full;
  logic signed [3:0]  cfg_sustain;
  logic signed [15:0] cfg_init;
  logic               cfg_step;

  // Envelope state as it should stand after every accepted word.
  logic [19:0]        tick_clock;
  logic [19:0]        seg_origin;
  logic [3:0]         seg_cursor;
  logic signed [15:0] level_now;
  logic signed [15:0] level_from;
  logic               env_ended;
  logic [15:0]        dur_tab [8];
  logic signed [15:0] tgt_tab [8];

  // Result words still owed by the block, oldest first.
  result_t levels_due [$];

  int bad_words = 0;
  int tx_idle_pct = 10;
  int rx_idle_pct = 10;
  int hold_left = 0;

  // Return to the first segment. A full restart also reloads the level.
  function automatic void rewind_envelope();
    env_ended = 1'b0;
    tick_clock = '0;
    seg_cursor = '0;
    seg_origin = '0;
    if (cfg_full) begin
      level_now = cfg_init;
    end
    level_from = level_now;
  endfunction

  // Apply one input word to the envelope state and return the word that the
  // block must report for it.
  function automatic result_t envelope_step(input item_t w);
    logic [3:0]  active;
    logic [19:0] spent;
    longint      delta;
    longint      ramp;
    logic        live;
    result_t     r;
    case (w.cmd)
      CMD_TICK: begin
        active = (cfg_count > 4'd8) ? 4'd8 : cfg_count;
        live = 1'b1;
        // Past the last segment the envelope either ends or starts over.
        if (seg_cursor >= active) begin
          if (!cfg_loop) begin
            env_ended = 1'b1;
            live = 1'b0;
          end else begin
            rewind_envelope();
            if (active == 4'd0) begin
              live = 1'b0;
            end
          end
        end
        if (live) begin
          spent = tick_clock - seg_origin;
          if (spent < {4'd0, dur_tab[seg_cursor]}) begin
            if (cfg_step) begin
              level_now = tgt_tab[seg_cursor];
            end else begin
              // Linear ramp; integer division truncates toward zero.
              delta = longint'(tgt_tab[seg_cursor]) - longint'(level_from);
              ramp = longint'(level_from) +
                     (delta * longint'(spent)) / longint'(dur_tab[seg_cursor]);
              if (ramp > 32767) begin
                level_now = 16'sh7fff;
              end else if (ramp < -32768) begin
                level_now = 16'sh8000;
              end else begin
                level_now = 16'(ramp);
              end
            end
            tick_clock = tick_clock + 20'd1;
          end else if (!(cfg_sustain >= 0 && $unsigned(cfg_sustain) == seg_cursor)) begin
            // The segment's time is used up: move on, level unchanged.
            seg_origin = seg_origin + {4'd0, dur_tab[seg_cursor]};
            level_from = tgt_tab[seg_cursor];
            seg_cursor = seg_cursor + 4'd1;
          end
        end
      end
      CMD_RESTART: begin
        rewind_envelope();
      end
      CMD_LOAD: begin
        dur_tab[w.seg_index] = w.seg_duration;
        tgt_tab[w.seg_index] = w.seg_level;
      end
      default: begin
      end
    endcase
    r.level_out = level_now;
    r.finished = env_ended;
    r.segment_now = seg_cursor;
    return r;
  endfunction

  // Offer one word, with a random gap before it, and wait until it is taken.
  // Valid is left high on return so that a word right behind it follows
  // without a bubble; a gap or the settle task lowers it.
  task automatic offer_word(input item_t w);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 32);
    end
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_word <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    levels_due.push_back(envelope_step(w));
  endtask

  // Stop offering and wait until every owed result word has come back.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all six registers on back-to-back cycles. Only called while idle.
  task automatic program_envelope(input logic [3:0] count, input logic loop_on,
                                  input logic full_on, input logic [3:0] sustain,
                                  input logic [15:0] init_level, input logic step_on);
    cfg_we <= 1'b1;
    cfg_index <= REG_SEGMENT_COUNT;
    cfg_data <= {12'd0, count};
    @(posedge clk);
    cfg_index <= REG_LOOP_ENABLE;
    cfg_data <= {15'd0, loop_on};
    @(posedge clk);
    cfg_index <= REG_FULL_RESTART;
    cfg_data <= {15'd0, full_on};
    @(posedge clk);
    cfg_index <= REG_SUSTAIN_SEGMENT;
    cfg_data <= {12'd0, sustain};
    @(posedge clk);
    cfg_index <= REG_INITIAL_LEVEL;
    cfg_data <= init_level;
    @(posedge clk);
    cfg_index <= REG_STEP_MODE;
    cfg_data <= {15'd0, step_on};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_count = count;
    cfg_loop = loop_on;
    cfg_full = full_on;
    cfg_sustain = sustain;
    cfg_init = init_level;
    cfg_step = step_on;
  endtask

  function automatic item_t make_word(input logic [1:0] cmd, input logic [2:0] idx,
                                      input logic [15:0] dur, input logic [15:0] lvl);
    item_t w;
    w.cmd = cmd;
    w.seg_index = idx;
    w.seg_duration = dur;
    w.seg_level = lvl;
    return w;
  endfunction

  // Mostly ticks, so that envelopes run through their segments, with loads
  // rewriting the table underneath and restarts pulling the cursor back.
  // Durations are short most of the time so that segment ends come often.
  function automatic item_t random_word();
    item_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      w.cmd = CMD_TICK;
    end else if (pick < 82) begin
      w.cmd = CMD_LOAD;
    end else if (pick < 93) begin
      w.cmd = CMD_RESTART;
    end else begin
      w.cmd = CMD_IDLE;
    end
    w.seg_index = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      w.seg_duration = 16'($urandom_range(0, 6));
    end else if (pick < 92) begin
      w.seg_duration = 16'($urandom_range(0, 65535));
    end else begin
      w.seg_duration = 16'hffff;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      w.seg_level = 16'sh8000;
    end else if (pick < 20) begin
      w.seg_level = 16'sh7fff;
    end else begin
      w.seg_level = 16'($urandom);
    end
    return w;
  endfunction

  // Ticks with no segments in use: without looping the envelope finishes at
  // once, with looping it restarts and holds the initial level. The unused
  // command code is sent here as well.
  task automatic test_empty_envelope();
    program_envelope(4'd0, 1'b0, 1'b0, 4'hf, 16'h0000, 1'b0);
    offer_word(make_word(CMD_TICK, 3'd0, 16'd0, 16'h0000));
    offer_word(make_word(CMD_IDLE, 3'd7, 16'hffff, 16'hffff));
    offer_word(make_word(CMD_RESTART, 3'd0, 16'd0, 16'h0000));
    settle();
    program_envelope(4'd0, 1'b1, 1'b1, 4'hf, 16'h7fff, 1'b0);
    offer_word(make_word(CMD_TICK, 3'd0, 16'd0, 16'h0000));
    offer_word(make_word(CMD_TICK, 3'd0, 16'd0, 16'h0000));
    settle();
  endtask

  // Fill every table entry, with the duration and level extremes and both
  // alternating bit patterns. Nothing reads the table before this.
  task automatic test_table_load();
    offer_word(make_word(CMD_LOAD, 3'd0, 16'd0, 16'h7fff));
    offer_word(make_word(CMD_LOAD, 3'd1, 16'hffff, 16'h8000));
    offer_word(make_word(CMD_LOAD, 3'd2, 16'd3, 16'hffff));
    offer_word(make_word(CMD_LOAD, 3'd3, 16'd1, 16'h0000));
    offer_word(make_word(CMD_LOAD, 3'd4, 16'd2, 16'h5555));
    offer_word(make_word(CMD_LOAD, 3'd5, 16'haaaa, 16'haaaa));
    offer_word(make_word(CMD_LOAD, 3'd6, 16'h5555, 16'h2aaa));
    offer_word(make_word(CMD_LOAD, 3'd7, 16'd4, 16'hfb2e));
    settle();
  endtask

  // A count beyond the table acts as a full table. The first segment has zero
  // length and is passed at once; the second ramps across the full level
  // range over the longest duration. Its duration is then cut below the time
  // already spent, which ends it, and since it is the sustain segment the
  // level holds there.
  task automatic test_ramp_hold();
    program_envelope(4'hf, 1'b0, 1'b1, 4'd1, 16'h8000, 1'b0);
    offer_word(make_word(CMD_RESTART, 3'd0, 16'd0, 16'h0000));
    repeat (4) offer_word(make_word(CMD_TICK, 3'd0, 16'd0, 16'h0000));
    offer_word(make_word(CMD_LOAD, 3'd1, 16'd2, 16'h8000));
    repeat (2) offer_word(make_word(CMD_TICK, 3'd0, 16'd0, 16'h0000));
    settle();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // block fills its result register and then stops taking input.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left = 300;
    repeat (8) offer_word(random_word());
    settle();
  endtask

  // Four settings per call: two fixed extremes, then two random ones.
  task automatic test_random(input int tx_pct, input int rx_pct);
    logic [3:0] count;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < 4; k++) begin
      if (k == 0) begin
        program_envelope(4'd8, 1'b1, 1'b1, 4'd7, 16'h7fff, 1'b1);
      end else if (k == 1) begin
        program_envelope(4'd1, 1'b0, 1'b0, 4'h8, 16'h8000, 1'b0);
      end else begin
        count = 4'($urandom_range(0, 9));
        if (count == 4'd9) begin
          count = 4'hf;
        end
        program_envelope(count, 1'($urandom), 1'($urandom), 4'($urandom),
                         16'($urandom), 1'($urandom));
      end
      repeat (55) offer_word(random_word());
      settle();
    end
  endtask

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Every result word taken from the block is compared with the oldest
  // owed word, field by field.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (levels_due.size() == 0) begin
        $error("result word with nothing owed: level_out %0d finished %0d segment_now %0d",
               result_word.level_out, result_word.finished, result_word.segment_now);
        bad_words++;
      end else begin
        if (result_word.level_out !== levels_due[0].level_out) begin
          $error("level_out: expected %0d, got %0d",
                 levels_due[0].level_out, result_word.level_out);
          bad_words++;
        end
        if (result_word.finished !== levels_due[0].finished) begin
          $error("finished: expected %0d, got %0d",
                 levels_due[0].finished, result_word.finished);
          bad_words++;
        end
        if (result_word.segment_now !== levels_due[0].segment_now) begin
          $error("segment_now: expected %0d, got %0d",
                 levels_due[0].segment_now, result_word.segment_now);
          bad_words++;
        end
        void'(levels_due.pop_front());
      end
    end
  end

  initial begin
    // The predictor starts from the reset state; the table is only read after
    // every entry has been loaded.
    cfg_count = 4'd0;
    cfg_loop = 1'b0;
    cfg_full = 1'b0;
    cfg_sustain = -4'sd1;
    cfg_init = '0;
    cfg_step = 1'b0;
    tick_clock = '0;
    seg_origin = '0;
    seg_cursor = '0;
    level_now = '0;
    level_from = '0;
    env_ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      dur_tab[i] = '0;
      tgt_tab[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_envelope();
    test_table_load();
    test_ramp_hold();
    test_backpressure();
    test_random(25, 45);
    test_random(45, 25);
    test_random(0, 0);
    // Give a stray extra result word time to show up before the verdict.
    repeat (64) @(posedge clk);
    if (bad_words == 0 && levels_due.size() == 0) begin
      $display("breakpoint_envelope_generator: match");
    end else begin
      $display("breakpoint_envelope_generator: mismatch");
    end
    $finish;
  end

  // A stuck handshake ends the run here.
  initial begin
    #2_000_000;
    $display("breakpoint_envelope_generator: mismatch");
    $finish;
  end

endmodule

FILE: breakpoint_envelope_generator.f
design/bpe_pkg.sv
design/bpe_ram.sv
design/bpe_sequencer.sv
design/bpe_datapath.sv
design/breakpoint_envelope_generator.sv
design/bpe_checker.sv
test/tb.sv
